// ===== rtl/sha256_byte_stream_hasher_unit_defines.svh =====
// Assertion helpers shared by the hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHA256_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sha256 assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SHA256_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sha256 assertion failed");

`endif

// ===== rtl/sha256_pkg.sv =====
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } byte_src_e;

  typedef struct packed {
    logic      shift;
    byte_src_e src;
    logic      count_msg;
    logic      start_blk;
    logic      round;
    logic      update;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic blk_last;
    logic pad_last;
    logic rnd_last;
    logic out_busy;
  } sts_t;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned BlkBytes  = 64;
  localparam int unsigned PadEnd    = 56;
  localparam int unsigned RndW      = $clog2(NumRounds);
  localparam int unsigned PosW      = $clog2(BlkBytes);
  localparam int unsigned LenW      = 61;

  localparam logic [7:0] PadMark = 8'h80;

  localparam logic [31:0] K_TAB [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr32(logic [31:0] x, int unsigned n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] big_sig0(logic [31:0] x);
    return rotr32(x, 2) ^ rotr32(x, 13) ^ rotr32(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(logic [31:0] x);
    return rotr32(x, 6) ^ rotr32(x, 11) ^ rotr32(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(logic [31:0] x);
    return rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(logic [31:0] x);
    return rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== rtl/sha256_dp.sv =====
`include "sha256_byte_stream_hasher_unit_defines.svh"

module sha256_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        byte_i,
  input  sha256_pkg::cmd_t  cmd_i,
  output sha256_pkg::sts_t  sts_o,
  output logic [255:0]      digest_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);
  import sha256_pkg::*;

  logic [15:0][31:0] w_q;
  logic [511:0]      w_flat;
  logic [31:0]       v_q [8];
  logic [31:0]       h_q [8];
  logic [PosW-1:0]   pos_q;
  logic [RndW-1:0]   rnd_q;
  logic [LenW-1:0]   len_q;
  logic [255:0]      out_q;
  logic              out_valid_q;

  logic [7:0]  byte_sel;
  logic [63:0] total_bits;
  logic [63:0] len_sh;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  assign w_flat = w_q;

  // total bit count, big-endian byte picked by the low position bits
  assign total_bits = {len_q, 3'b000};
  assign len_sh     = total_bits >> {~pos_q[2:0], 3'b000};

  always_comb begin
    case (cmd_i.src)
      SRC_MSG:  byte_sel = byte_i;
      SRC_MARK: byte_sel = PadMark;
      SRC_ZERO: byte_sel = 8'h00;
      SRC_LEN:  byte_sel = len_sh[7:0];
      default:  byte_sel = 8'h00;
    endcase
  end

  // oldest schedule word sits in w_q[15]
  assign w_new = small_sig1(w_q[1]) + w_q[6] + small_sig0(w_q[14]) + w_q[15];
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + big_sig1(v_q[4]) + ch + K_TAB[rnd_q] + w_q[15];
  assign t2    = big_sig0(v_q[0]) + maj;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      w_q <= {w_flat[503:0], byte_sel};
    end else if (cmd_i.round) begin
      w_q <= {w_flat[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_blk) begin
      v_q <= h_q;
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= IV_TAB;
    end else if (cmd_i.emit) begin
      h_q <= IV_TAB;
    end else if (cmd_i.update) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      len_q <= '0;
      rnd_q <= '0;
    end else begin
      if (cmd_i.emit) begin
        pos_q <= '0;
        len_q <= '0;
      end else begin
        if (cmd_i.shift) begin
          pos_q <= pos_q + 1'b1;
        end
        if (cmd_i.count_msg) begin
          len_q <= len_q + 1'b1;
        end
      end
      if (cmd_i.start_blk) begin
        rnd_q <= '0;
      end else if (cmd_i.round) begin
        rnd_q <= rnd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      for (int i = 0; i < 4; i++) begin
        out_q[64*i +: 64] <= {h_q[2*i], h_q[2*i+1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.blk_last = (pos_q == PosW'(BlkBytes - 1));
  assign sts_o.pad_last = (pos_q == PosW'(PadEnd - 1));
  assign sts_o.rnd_last = (rnd_q == RndW'(NumRounds - 1));
  assign sts_o.out_busy = out_valid_q;

  assign digest_o    = out_q;
  assign out_valid_o = out_valid_q;

  `SHA256_ASSERT_SAME(a_emit_slot_free, clk_i, rst_ni, cmd_i.emit, !out_valid_q)
  `SHA256_ASSERT_SAME(a_emit_block_aligned, clk_i, rst_ni, cmd_i.emit, pos_q == '0)
  `SHA256_ASSERT_NEXT(a_block_start, clk_i, rst_ni, cmd_i.start_blk, rnd_q == '0 && pos_q == '0)

endmodule

// ===== rtl/sha256_ctrl.sv =====
`include "sha256_byte_stream_hasher_unit_defines.svh"

module sha256_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_present_i,
  input  logic              in_end_i,
  output logic              in_ready_o,
  input  sha256_pkg::sts_t  sts_i,
  output sha256_pkg::cmd_t  cmd_o
);
  import sha256_pkg::*;

  state_e state_q, state_d;
  logic   end_pend_q, end_pend_d;
  logic   marked_q, marked_d;
  logic   final_q, final_d;
  logic   acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    end_pend_d = end_pend_q;
    marked_d   = marked_q;
    final_d    = final_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (in_present_i && sts_i.blk_last) begin
            state_d    = ST_ROUND;
            end_pend_d = in_end_i;
          end else if (in_end_i) begin
            state_d = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        marked_d = 1'b1;
        if (sts_i.blk_last) begin
          state_d = ST_ROUND;
        end else if (sts_i.pad_last) begin
          state_d = ST_LEN;
        end else begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (sts_i.blk_last) begin
          state_d = ST_ROUND;
        end else if (sts_i.pad_last) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (sts_i.blk_last) begin
          state_d = ST_ROUND;
          final_d = 1'b1;
        end
      end
      ST_ROUND: begin
        if (sts_i.rnd_last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (final_q) begin
          state_d = ST_OUT;
        end else if (marked_q) begin
          state_d = ST_ZERO;
        end else if (end_pend_q) begin
          state_d    = ST_MARK;
          end_pend_d = 1'b0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          state_d    = ST_IDLE;
          end_pend_d = 1'b0;
          marked_d   = 1'b0;
          final_d    = 1'b0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.src = SRC_MSG;
        if (acc && in_present_i) begin
          cmd_o.shift     = 1'b1;
          cmd_o.count_msg = 1'b1;
          cmd_o.start_blk = sts_i.blk_last;
        end
      end
      ST_MARK: begin
        cmd_o.shift     = 1'b1;
        cmd_o.src       = SRC_MARK;
        cmd_o.start_blk = sts_i.blk_last;
      end
      ST_ZERO: begin
        cmd_o.shift     = 1'b1;
        cmd_o.src       = SRC_ZERO;
        cmd_o.start_blk = sts_i.blk_last;
      end
      ST_LEN: begin
        cmd_o.shift     = 1'b1;
        cmd_o.src       = SRC_LEN;
        cmd_o.start_blk = sts_i.blk_last;
      end
      ST_ROUND:  cmd_o.round  = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_OUT:    cmd_o.emit   = !sts_i.out_busy;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      end_pend_q <= 1'b0;
      marked_q   <= 1'b0;
      final_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      end_pend_q <= end_pend_d;
      marked_q   <= marked_d;
      final_q    <= final_d;
    end
  end

  `SHA256_ASSERT_NEXT(a_last_round, clk_i, rst_ni, state_q == ST_ROUND && sts_i.rnd_last, state_q == ST_UPDATE)

endmodule

// ===== rtl/sha256_byte_stream_hasher_unit.sv =====
// Message bytes: one transfer per cycle while idle; a 64th byte starts the 64 rounds of the block
// and then a chaining update, and no transfer is taken until the controller is idle again.
// Message end: padding bytes go in at one per cycle up to the block end, then one or two
// compressions follow, and the digest register is loaded once the previous digest is taken.
// Reset (rst_ni low, asynchronous): chaining words return to the initial hash values, counters
// and the control machine clear, and no digest is pending.
module sha256_byte_stream_hasher_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] msg_byte
  input  logic         s_axis_tuser_i,   // [0] byte_present
  input  logic         s_axis_tlast_i,   // message_end
  // digest stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [255:0] m_axis_tdata_o    // [63:0] digest_word0, [127:64] digest_word1,
                                         // [191:128] digest_word2, [255:192] digest_word3
);
  import sha256_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: accept a transfer only in the idle state, sequence padding, rounds
  // and the digest hand-off.
  sha256_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_present_i (s_axis_tuser_i),
    .in_end_i     (s_axis_tlast_i),
    .in_ready_o   (s_axis_tready_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Datapath: block/schedule shift line, one SHA-256 round per cycle, chaining
  // words, length counter and the registered digest output.
  sha256_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .digest_o    (m_axis_tdata_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i)
  );

endmodule
